>>> hw/rtl/card_detect_mount_retry_fsm_macros.svh
// Assertion helpers for the card detect block.
`ifndef CARD_DETECT_MOUNT_RETRY_FSM_MACROS_SVH
`define CARD_DETECT_MOUNT_RETRY_FSM_MACROS_SVH

`ifndef SYNTHESIS

`define CDMR_ASSERT_SAME(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("cdmr: same-cycle check failed");

`define CDMR_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("cdmr: next-cycle check failed");

`else

`define CDMR_ASSERT_SAME(label, clk, rst_n, pre, post)

`define CDMR_ASSERT_NEXT(label, clk, rst_n, pre, post)

`endif

`endif

>>> hw/rtl/cdmr_pkg.sv
package cdmr_pkg;

    localparam int TICK_W = 16;
    localparam int ATT_W  = 4;
    localparam int IDX_W  = 3;

    localparam logic [TICK_W-1:0] STABLE_MAX = {TICK_W{1'b1}};
    localparam logic [ATT_W-1:0]  ATT_MAX    = {ATT_W{1'b1}};

    localparam logic [TICK_W-1:0] DEBOUNCE_RST = 16'd50;
    localparam logic [TICK_W-1:0] SETTLE_RST   = 16'd500;
    localparam logic [TICK_W-1:0] RETRY_RST    = 16'd1000;
    localparam logic [ATT_W-1:0]  MAX_ATT_RST  = 4'd3;
    localparam logic [TICK_W-1:0] BACKOFF_RST  = 16'd2000;

    typedef enum logic [1:0] {
        MODE_ABSENT   = 2'd0,
        MODE_MOUNTING = 2'd1,
        MODE_READY    = 2'd2,
        MODE_ERROR    = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ERR_NONE    = 2'd0,
        ERR_REMOVED = 2'd1,
        ERR_MOUNT   = 2'd2
    } t_err;

    typedef enum logic [IDX_W-1:0] {
        CFG_DEBOUNCE = 3'd0,
        CFG_SETTLE   = 3'd1,
        CFG_RETRY    = 3'd2,
        CFG_MAX_ATT  = 3'd3,
        CFG_BACKOFF  = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic raw_detect;
        logic mount_ok;
    } t_in_item;

    typedef struct packed {
        logic             mount_request;
        logic             card_present;
        logic [1:0]       mount_mode;
        logic [ATT_W-1:0] attempt_count;
        logic [1:0]       error_code;
    } t_out_item;

    typedef struct packed {
        logic [TICK_W-1:0] debounce_ticks;
        logic [TICK_W-1:0] settle_ticks;
        logic [TICK_W-1:0] retry_ticks;
        logic [ATT_W-1:0]  max_attempts;
        logic [TICK_W-1:0] error_backoff_ticks;
    } t_cfg;

    typedef struct packed {
        logic              filtered;
        logic              present;
        logic [TICK_W-1:0] stable;
        t_mode             mode;
        logic [ATT_W-1:0]  attempts;
        logic [TICK_W-1:0] wait_cnt;
        t_err              err;
    } t_state;

endpackage

>>> hw/rtl/cdmr_step.sv
module cdmr_step (
    input  cdmr_pkg::t_state    i_state,
    input  cdmr_pkg::t_cfg      i_cfg,
    input  cdmr_pkg::t_in_item  i_item,
    output cdmr_pkg::t_state    o_state,
    output cdmr_pkg::t_out_item o_result
);
    import cdmr_pkg::*;

    t_state s;
    logic   req;

    always_comb begin
        s   = i_state;
        req = 1'b0;

        if (s.wait_cnt != '0) begin
            s.wait_cnt = s.wait_cnt - TICK_W'(1);
        end

        // a raw change restarts the stable count
        if (i_item.raw_detect != s.filtered) begin
            s.filtered = i_item.raw_detect;
            s.stable   = '0;
        end else if (s.stable != STABLE_MAX) begin
            s.stable = s.stable + TICK_W'(1);
        end

        if (s.stable >= i_cfg.debounce_ticks && s.filtered != s.present) begin
            s.present  = s.filtered;
            s.attempts = '0;
            if (s.filtered) begin
                s.mode     = MODE_MOUNTING;
                s.wait_cnt = i_cfg.settle_ticks;
                s.err      = ERR_NONE;
            end else begin
                s.mode     = MODE_ABSENT;
                s.wait_cnt = '0;
                s.err      = ERR_REMOVED;
            end
        end

        if (s.present && s.mode != MODE_READY && s.wait_cnt == '0) begin
            req = 1'b1;
            if (s.attempts != ATT_MAX) begin
                s.attempts = s.attempts + ATT_W'(1);
            end
            if (i_item.mount_ok) begin
                s.mode     = MODE_READY;
                s.attempts = '0;
                s.err      = ERR_NONE;
            end else begin
                s.err = ERR_MOUNT;
                if (s.attempts >= i_cfg.max_attempts) begin
                    s.mode     = MODE_ERROR;
                    s.attempts = '0;
                    s.wait_cnt = i_cfg.error_backoff_ticks;
                end else begin
                    s.wait_cnt = i_cfg.retry_ticks;
                end
            end
        end
    end

    assign o_state                = s;
    assign o_result.mount_request = req;
    assign o_result.card_present  = s.present;
    assign o_result.mount_mode    = s.mode;
    assign o_result.attempt_count = s.attempts;
    assign o_result.error_code    = s.err;

endmodule

>>> hw/rtl/card_detect_mount_retry_fsm.sv
// Debounced card detect with mount retry. Each transfer on the input channel is one
// millisecond tick carrying the raw detect level and the outcome a mount would give;
// each tick yields exactly one result transfer with the request flag, debounced
// presence, mount mode, failed attempt count and error code. The block takes one tick
// per clock cycle while the result output is not held. A tick is held in the input
// register, and the single-pass state update loads its result into the result register
// as the tick advances. A result that waits on the output holds the input once both
// registers are full. The configuration registers reset to debounce 50, settle 500,
// retry 1000, three attempts and backoff 2000 ticks; the user must write them only while
// no tick is in flight, and the block itself does not enforce this.
`include "card_detect_mount_retry_fsm_macros.svh"

module card_detect_mount_retry_fsm (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [cdmr_pkg::IDX_W-1:0]          i_cfg_addr,
    input  logic [cdmr_pkg::TICK_W-1:0]         i_cfg_wdata,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  cdmr_pkg::t_in_item                  i_in,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output cdmr_pkg::t_out_item                 o_out
);
    import cdmr_pkg::*;

    t_cfg      r_cfg;
    t_state    r_state;
    t_state    n_state;
    t_in_item  r_in;
    logic      r_in_vld;
    t_out_item r_out;
    t_out_item n_out;
    logic      r_out_vld;
    logic      advance;

    // advance the held tick whenever the result slot is free or drains this cycle
    assign advance    = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ticks      <= DEBOUNCE_RST;
            r_cfg.settle_ticks        <= SETTLE_RST;
            r_cfg.retry_ticks         <= RETRY_RST;
            r_cfg.max_attempts        <= MAX_ATT_RST;
            r_cfg.error_backoff_ticks <= BACKOFF_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_addr))
                CFG_DEBOUNCE: r_cfg.debounce_ticks      <= i_cfg_wdata;
                CFG_SETTLE:   r_cfg.settle_ticks        <= i_cfg_wdata;
                CFG_RETRY:    r_cfg.retry_ticks         <= i_cfg_wdata;
                CFG_MAX_ATT:  r_cfg.max_attempts        <= i_cfg_wdata[ATT_W-1:0];
                CFG_BACKOFF:  r_cfg.error_backoff_ticks <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    cdmr_step u_step (
        .i_state  (r_state),
        .i_cfg    (r_cfg),
        .i_item   (r_in),
        .o_state  (n_state),
        .o_result (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld         <= 1'b0;
            r_out_vld        <= 1'b0;
            r_state.filtered <= 1'b0;
            r_state.present  <= 1'b0;
            r_state.stable   <= '0;
            r_state.mode     <= MODE_ABSENT;
            r_state.attempts <= '0;
            r_state.wait_cnt <= '0;
            r_state.err      <= ERR_NONE;
        end else begin
            if (o_in_ready) begin
                r_in_vld <= i_in_valid;
            end
            if (advance) begin
                r_out_vld <= 1'b1;
                r_state   <= n_state;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

    `CDMR_ASSERT_SAME(a_mode_tracks_presence, i_clk, i_rst_n, o_out_valid,
        (o_out.card_present == (o_out.mount_mode != MODE_ABSENT)))
    `CDMR_ASSERT_SAME(a_request_needs_card, i_clk, i_rst_n,
        o_out_valid && o_out.mount_request, o_out.card_present)
    `CDMR_ASSERT_SAME(a_ready_clears_attempts, i_clk, i_rst_n,
        r_state.mode == MODE_READY, r_state.attempts == '0)
    `CDMR_ASSERT_NEXT(a_advance_fills_result, i_clk, i_rst_n, advance, r_out_vld)

endmodule

>>> sim/tb_card_detect_mount_retry_fsm.sv
module tb_card_detect_mount_retry_fsm;
    import cdmr_pkg::*;

    localparam int QUIET_LIMIT = 3000;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 10;
    localparam int NUM_REGS = 5;

    class card_status_board;
        t_cfg      cfg;
        t_state    st;
        t_out_item status_q[$];
        int        errors;

        function new();
            cfg.debounce_ticks      = DEBOUNCE_RST;
            cfg.settle_ticks        = SETTLE_RST;
            cfg.retry_ticks         = RETRY_RST;
            cfg.max_attempts        = MAX_ATT_RST;
            cfg.error_backoff_ticks = BACKOFF_RST;
            st.filtered = 1'b0;
            st.present  = 1'b0;
            st.stable   = '0;
            st.mode     = MODE_ABSENT;
            st.attempts = '0;
            st.wait_cnt = '0;
            st.err      = ERR_NONE;
            errors      = 0;
        endfunction

        function void write_reg(logic [IDX_W-1:0] idx, logic [TICK_W-1:0] data);
            case (idx)
                CFG_DEBOUNCE: cfg.debounce_ticks      = data;
                CFG_SETTLE:   cfg.settle_ticks        = data;
                CFG_RETRY:    cfg.retry_ticks         = data;
                CFG_MAX_ATT:  cfg.max_attempts        = data[ATT_W-1:0];
                CFG_BACKOFF:  cfg.error_backoff_ticks = data;
                default: ;
            endcase
        endfunction

        // Advance the card state by one tick and queue the status it yields.
        function void note_tick(t_in_item it);
            t_out_item want;
            logic      request;
            request = 1'b0;
            if (st.wait_cnt != '0)
                st.wait_cnt = st.wait_cnt - TICK_W'(1);
            if (it.raw_detect != st.filtered) begin
                st.filtered = it.raw_detect;
                st.stable   = '0;
            end else if (st.stable != STABLE_MAX) begin
                st.stable = st.stable + TICK_W'(1);
            end
            if (st.stable >= cfg.debounce_ticks && st.filtered != st.present) begin
                st.present  = st.filtered;
                st.attempts = '0;
                if (st.present) begin
                    st.mode     = MODE_MOUNTING;
                    st.wait_cnt = cfg.settle_ticks;
                    st.err      = ERR_NONE;
                end else begin
                    st.mode     = MODE_ABSENT;
                    st.wait_cnt = '0;
                    st.err      = ERR_REMOVED;
                end
            end
            if (st.present && st.mode != MODE_READY && st.wait_cnt == '0) begin
                request = 1'b1;
                if (st.attempts != ATT_MAX)
                    st.attempts = st.attempts + ATT_W'(1);
                if (it.mount_ok) begin
                    st.mode     = MODE_READY;
                    st.attempts = '0;
                    st.err      = ERR_NONE;
                end else begin
                    st.err = ERR_MOUNT;
                    if (st.attempts >= cfg.max_attempts) begin
                        st.mode     = MODE_ERROR;
                        st.attempts = '0;
                        st.wait_cnt = cfg.error_backoff_ticks;
                    end else begin
                        st.wait_cnt = cfg.retry_ticks;
                    end
                end
            end
            want.mount_request = request;
            want.card_present  = st.present;
            want.mount_mode    = st.mode;
            want.attempt_count = st.attempts;
            want.error_code    = st.err;
            status_q.push_back(want);
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $error("%s: expected %0d, actual %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (status_q.size() == 0) begin
                $error("status transfer with no tick pending");
                errors++;
                return;
            end
            want = status_q.pop_front();
            compare_field("mount_request", 32'(want.mount_request), 32'(got.mount_request));
            compare_field("card_present", 32'(want.card_present), 32'(got.card_present));
            compare_field("mount_mode", 32'(want.mount_mode), 32'(got.mount_mode));
            compare_field("attempt_count", 32'(want.attempt_count), 32'(got.attempt_count));
            compare_field("error_code", 32'(want.error_code), 32'(got.error_code));
        endfunction

        function int pending();
            return status_q.size();
        endfunction
    endclass

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_cfg_we    = 1'b0;
    logic [IDX_W-1:0]  i_cfg_addr  = '0;
    logic [TICK_W-1:0] i_cfg_wdata = '0;
    logic              i_in_valid  = 1'b0;
    logic              o_in_ready;
    t_in_item          i_in        = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    t_out_item         o_out;

    card_status_board board;
    int               idle_pct   = 6;
    bit               stall_req  = 1'b0;
    logic             line_level = 1'b0;
    int               quiet_cycles = 0;

    card_detect_mount_retry_fsm dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    always #5 i_clk = ~i_clk;

    // Receiver: random backpressure, plus one long hold when asked.
    initial begin
        forever begin
            @(negedge i_clk);
            if (stall_req) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                stall_req = 1'b0;
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= ($urandom_range(99) >= idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            board.check_result(o_out);
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic t_in_item tick(logic raw, logic ok);
        t_in_item it;
        it.raw_detect = raw;
        it.mount_ok   = ok;
        return it;
    endfunction

    function automatic t_cfg make_cfg(int deb, int settle, int retry, int att, int backoff);
        t_cfg c;
        c.debounce_ticks      = TICK_W'(deb);
        c.settle_ticks        = TICK_W'(settle);
        c.retry_ticks         = TICK_W'(retry);
        c.max_attempts        = ATT_W'(att);
        c.error_backoff_ticks = TICK_W'(backoff);
        return c;
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_tick(t_in_item it);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= it;
        do @(posedge i_clk); while (!o_in_ready);
        board.note_tick(it);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (board.pending() != 0) @(negedge i_clk);
    endtask

    task automatic program_regs(t_cfg c);
        logic [TICK_W-1:0] vals [NUM_REGS];
        logic [IDX_W-1:0]  stray_idx;
        logic [TICK_W-1:0] stray_data;
        vals[CFG_DEBOUNCE] = c.debounce_ticks;
        vals[CFG_SETTLE]   = c.settle_ticks;
        vals[CFG_RETRY]    = c.retry_ticks;
        // Junk in the upper bits must be dropped.
        vals[CFG_MAX_ATT]  = {(TICK_W-ATT_W)'($urandom), c.max_attempts};
        vals[CFG_BACKOFF]  = c.error_backoff_ticks;
        for (int k = 0; k < NUM_REGS; k++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_addr  <= IDX_W'(k);
            i_cfg_wdata <= vals[k];
            board.write_reg(IDX_W'(k), vals[k]);
            @(negedge i_clk);
        end
        // Unmapped index: no effect.
        stray_idx  = IDX_W'(NUM_REGS + $urandom_range(2));
        stray_data = TICK_W'($urandom);
        i_cfg_addr  <= stray_idx;
        i_cfg_wdata <= stray_data;
        board.write_reg(stray_idx, stray_data);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Mostly a steady detect line with rare moves and one-tick glitches, or fully random ticks when noise is set.
    task automatic run_random(int n, int ok_pct, bit noise, int stall_at, int pause_at);
        int r;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(99);
            if (r < 3)
                line_level = ~line_level;
            if (k == stall_at)
                stall_req = 1'b1;
            if (k == pause_at)
                drain();
            if (noise)
                send_tick(tick(1'($urandom_range(1)), 1'($urandom_range(1))));
            else
                send_tick(tick((r >= 3 && r < 8) ? ~line_level : line_level,
                               $urandom_range(99) < ok_pct));
        end
    endtask

    initial begin
        board = new();
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset configuration: card goes in but debounce holds it off.
        repeat (3) send_tick(tick(1'b1, 1'b0));
        send_tick(tick(1'b0, 1'b1));
        send_tick(tick(1'b1, 1'b1));
        drain();

        // Zero delays: insertion, attempt and outcome all in one tick.
        program_regs(make_cfg(0, 0, 0, 1, 0));
        send_tick(tick(1'b1, 1'b0));
        send_tick(tick(1'b1, 1'b1));
        send_tick(tick(1'b1, 1'b0));
        send_tick(tick(1'b0, 1'b1));
        send_tick(tick(1'b0, 1'b0));
        send_tick(tick(1'b1, 1'b1));
        drain();

        // Short debounce with a glitch, then settle, retries and error backoff.
        program_regs(make_cfg(2, 3, 2, 2, 4));
        send_tick(tick(1'b0, 1'b0));
        send_tick(tick(1'b1, 1'b0));
        repeat (3) send_tick(tick(1'b0, 1'b0));
        repeat (10) send_tick(tick(1'b1, 1'b0));
        send_tick(tick(1'b1, 1'b1));
        line_level = 1'b1;
        drain();

        // Zero max attempts: first failure goes straight to error.
        program_regs(make_cfg(0, 0, 0, 0, 0));
        run_random(100, 30, 1'b0, -1, -1);
        drain();

        program_regs(make_cfg(1, 2, 0, 15, 3));
        run_random(120, 3, 1'b0, -1, -1);
        drain();

        program_regs(make_cfg(65535, 65535, 65535, 15, 65535));
        run_random(30, 50, 1'b0, -1, -1);
        drain();

        for (int p = 0; p < 5; p++) begin
            program_regs(make_cfg($urandom_range(6), $urandom_range(12), $urandom_range(8),
                                  $urandom_range(5), $urandom_range(20)));
            idle_pct = (p == 1) ? 0 : 6;
            run_random(110, 10 + $urandom_range(40), p == 3,
                       (p == 2) ? 20 : -1, (p == 4) ? 50 : -1);
            drain();
        end

        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (board.errors == 0 && board.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
